/* hdl/fvm_pkg.sv */
package fvm_pkg;

	localparam int unsigned REPLAY_WIN_DEF = 64;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [2:0] {
		MODE_GET_TX        = 3'd0,
		MODE_VERIFY        = 3'd1,
		MODE_INC_COUNT     = 3'd2,
		MODE_INC_TRIP      = 3'd3,
		MODE_INC_RESET     = 3'd4,
		MODE_SYNC_APPLY    = 3'd5,
		MODE_FORCE_RESYNC  = 3'd6,
		MODE_SYNC_RESPONSE = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		CS_OK          = 3'd0,
		CS_NOT_SYNC    = 3'd1,
		CS_SYNC_BUSY   = 3'd2,
		CS_SYNC_FAILED = 3'd3,
		CS_REPLAY      = 3'd4,
		CS_OVERFLOW    = 3'd5
	} chan_state_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_SYNC_FAIL = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_REPLAY    = 3'd4;

	localparam logic [1:0] ROLE_MASTER = 2'd1;
	localparam logic [1:0] ROLE_SLAVE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FV_KIND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ROLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REORDER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIP_LIM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LIM = 3'd6;

	localparam logic [63:0] MAX_COUNT_RST = 64'hFF_FFFF;
	localparam logic [31:0] TRIP_LIM_RST  = 32'hFFFF_FFFF;
	localparam logic [7:0]  RESET_LIM_RST = 8'hFF;

	// length code thresholds
	localparam logic [63:0] LEN4_THR = 64'hFF_FFFF;
	localparam logic [63:0] LEN3_THR = 64'hFFFF;
	localparam logic [63:0] LEN2_THR = 64'hFF;

	localparam logic [3:0] LEN_1B = 4'd1;
	localparam logic [3:0] LEN_2B = 4'd2;
	localparam logic [3:0] LEN_3B = 4'd3;
	localparam logic [3:0] LEN_4B = 4'd4;
	localparam logic [3:0] LEN_8B = 4'd8;

	typedef struct packed {
		logic        fv_kind;
		logic [1:0]  sync_role;
		logic [63:0] max_count;
		logic [31:0] sync_gap_limit;
		logic [31:0] reorder_tolerance;
		logic [31:0] trip_limit;
		logic [7:0]  reset_limit;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [63:0] rx_value;
		logic [31:0] sync_trip;
		logic [7:0]  sync_reset;
		logic [63:0] sync_mac;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] tx_value;
		logic [3:0]  tx_length;
		logic [31:0] out_trip;
		logic [7:0]  out_reset;
		logic [2:0]  fv_state;
	} result_t;

endpackage

/* hdl/fvm_cfg.sv */
module fvm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [fvm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [63:0]                      wr_data,
	output fvm_pkg::cfg_t                    cfg
);

	fvm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fv_kind           <= 1'b0;
			cfg_q.sync_role         <= 2'd0;
			cfg_q.max_count         <= fvm_pkg::MAX_COUNT_RST;
			cfg_q.sync_gap_limit    <= 32'd0;
			cfg_q.reorder_tolerance <= 32'd0;
			cfg_q.trip_limit        <= fvm_pkg::TRIP_LIM_RST;
			cfg_q.reset_limit       <= fvm_pkg::RESET_LIM_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				fvm_pkg::CFG_FV_KIND:   cfg_q.fv_kind           <= wr_data[0];
				fvm_pkg::CFG_SYNC_ROLE: cfg_q.sync_role         <= wr_data[1:0];
				fvm_pkg::CFG_MAX_COUNT: cfg_q.max_count         <= wr_data;
				fvm_pkg::CFG_GAP_LIMIT: cfg_q.sync_gap_limit    <= wr_data[31:0];
				fvm_pkg::CFG_REORDER:   cfg_q.reorder_tolerance <= wr_data[31:0];
				fvm_pkg::CFG_TRIP_LIM:  cfg_q.trip_limit        <= wr_data[31:0];
				fvm_pkg::CFG_RESET_LIM: cfg_q.reset_limit       <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/fvm_engine.sv */
module fvm_engine #(
	parameter int unsigned REPLAY_WIN = fvm_pkg::REPLAY_WIN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  fvm_pkg::req_t     req,
	input  fvm_pkg::cfg_t     cfg,
	output fvm_pkg::result_t  res
);

	localparam logic [63:0] WIN = 64'(REPLAY_WIN);
	localparam logic [63:0] HALF = 64'(REPLAY_WIN / 2);

	logic [63:0] send_q, recv_q, last_good_q, win_base_q;
	logic [31:0] trip_q;
	logic [7:0]  reset_q;
	logic        in_sync_q;
	fvm_pkg::chan_state_t cs_q;

	logic [63:0] send_d, recv_d, last_good_d, win_base_d;
	logic [31:0] trip_d;
	logic [7:0]  reset_d;
	logic        in_sync_d;
	fvm_pkg::chan_state_t cs_d;

	logic [63:0] v, win_off, below, gap, rc;
	logic [31:0] rt;
	logic [7:0]  rr;
	logic        win_hit, tol_hit, gap_hit, trip_replay, is_slave, is_master;
	logic        can_bump_trip;
	logic [3:0]  len_code;

	always_comb begin
		v       = req.rx_value;
		win_off = v - win_base_q;
		below   = last_good_q - v;
		gap     = (v > recv_q) ? (v - recv_q) : 64'd0;
		win_hit = (v >= win_base_q) && (win_off < WIN) && (v <= last_good_q);
		tol_hit = (v <= last_good_q) && (below > {32'd0, cfg.reorder_tolerance});
		is_slave  = (cfg.sync_role == fvm_pkg::ROLE_SLAVE);
		is_master = (cfg.sync_role == fvm_pkg::ROLE_MASTER);
		gap_hit = is_slave && (gap > {32'd0, cfg.sync_gap_limit});

		// trip/reset/counter fields of a received value
		rt = v[63:32];
		rr = v[31:24];
		rc = {40'd0, v[23:0]};
		trip_replay = (rt < trip_q) ||
			((rt == trip_q) && (rr < reset_q)) ||
			((rt == trip_q) && (rr == reset_q) && (rc <= last_good_q));

		can_bump_trip = (trip_q < cfg.trip_limit);

		if (cfg.max_count > fvm_pkg::LEN4_THR)      len_code = fvm_pkg::LEN_4B;
		else if (cfg.max_count > fvm_pkg::LEN3_THR) len_code = fvm_pkg::LEN_3B;
		else if (cfg.max_count > fvm_pkg::LEN2_THR) len_code = fvm_pkg::LEN_2B;
		else                                        len_code = fvm_pkg::LEN_1B;
	end

	always_comb begin
		send_d      = send_q;
		recv_d      = recv_q;
		last_good_d = last_good_q;
		win_base_d  = win_base_q;
		trip_d      = trip_q;
		reset_d     = reset_q;
		in_sync_d   = in_sync_q;
		cs_d        = cs_q;
		res.status    = fvm_pkg::ST_OK;
		res.tx_value  = 64'd0;
		res.tx_length = 4'd0;
		res.out_trip  = 32'd0;
		res.out_reset = 8'd0;

		unique case (req.mode)
			fvm_pkg::MODE_GET_TX: begin
				if (!cfg.fv_kind) begin
					if (is_slave && !in_sync_q) begin
						cs_d = fvm_pkg::CS_NOT_SYNC;
						res.status = fvm_pkg::ST_SYNC_FAIL;
					end else if (send_q >= cfg.max_count) begin
						cs_d = fvm_pkg::CS_OVERFLOW;
						res.status = fvm_pkg::ST_OVERFLOW;
					end else begin
						res.tx_value  = send_q;
						res.tx_length = len_code;
					end
				end else begin
					res.tx_value  = {trip_q, reset_q, send_q[23:0]};
					res.tx_length = fvm_pkg::LEN_8B;
				end
			end
			fvm_pkg::MODE_VERIFY: begin
				if (!cfg.fv_kind) begin
					if (win_hit || tol_hit) begin
						cs_d = fvm_pkg::CS_REPLAY;
						res.status = fvm_pkg::ST_REPLAY;
					end else if (gap_hit) begin
						cs_d = fvm_pkg::CS_SYNC_BUSY;
						res.status = fvm_pkg::ST_SYNC_FAIL;
					end else begin
						recv_d      = v;
						last_good_d = v;
						cs_d        = fvm_pkg::CS_OK;
						win_base_d  = (v > HALF) ? (v - HALF) : 64'd0;
					end
				end else if (trip_replay) begin
					cs_d = fvm_pkg::CS_REPLAY;
					res.status = fvm_pkg::ST_REPLAY;
				end else begin
					last_good_d = rc;
					cs_d        = fvm_pkg::CS_OK;
				end
			end
			fvm_pkg::MODE_INC_COUNT: begin
				if (send_q < cfg.max_count) send_d = send_q + 64'd1;
			end
			fvm_pkg::MODE_INC_TRIP: begin
				if (can_bump_trip) begin
					trip_d = trip_q + 32'd1;
					send_d = 64'd1;
				end
			end
			fvm_pkg::MODE_INC_RESET: begin
				if (reset_q < cfg.reset_limit) begin
					reset_d = reset_q + 8'd1;
					send_d  = 64'd1;
				end else begin
					// reset counter rolls over into the trip counter
					if (can_bump_trip) begin
						trip_d = trip_q + 32'd1;
						send_d = 64'd1;
					end
					reset_d = 8'd0;
				end
			end
			fvm_pkg::MODE_SYNC_APPLY: begin
				if (!is_slave) begin
					res.status = fvm_pkg::ST_INVALID;
				end else if (req.sync_mac != v) begin
					cs_d = fvm_pkg::CS_SYNC_FAILED;
					res.status = fvm_pkg::ST_SYNC_FAIL;
				end else begin
					recv_d      = v;
					trip_d      = req.sync_trip;
					reset_d     = req.sync_reset;
					last_good_d = v;
					in_sync_d   = 1'b1;
					cs_d        = fvm_pkg::CS_OK;
				end
			end
			fvm_pkg::MODE_FORCE_RESYNC: begin
				if (!is_slave) begin
					res.status = fvm_pkg::ST_INVALID;
				end else begin
					cs_d = fvm_pkg::CS_SYNC_BUSY;
					in_sync_d = 1'b0;
					res.tx_value = {32'd0, recv_q[31:0]};
				end
			end
			fvm_pkg::MODE_SYNC_RESPONSE: begin
				if (!is_master) begin
					res.status = fvm_pkg::ST_INVALID;
				end else begin
					res.tx_value  = send_q;
					res.out_trip  = trip_q;
					res.out_reset = reset_q;
				end
			end
			default: ;
		endcase

		res.fv_state = cs_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_q      <= 64'd1;
			recv_q      <= 64'd0;
			last_good_q <= 64'd0;
			win_base_q  <= 64'd0;
			trip_q      <= 32'd1;
			reset_q     <= 8'd0;
			in_sync_q   <= 1'b0;
			cs_q        <= fvm_pkg::CS_NOT_SYNC;
		end else if (fire) begin
			send_q      <= send_d;
			recv_q      <= recv_d;
			last_good_q <= last_good_d;
			win_base_q  <= win_base_d;
			trip_q      <= trip_d;
			reset_q     <= reset_d;
			in_sync_q   <= in_sync_d;
			cs_q        <= cs_d;
		end
	end

endmodule

/* hdl/freshness_value_manager_core.sv */
// pipeline: a request is taken into the request register, and its result into the result register
// throughput: one request per cycle while out_stall is low; the event logic between the request
// register and the result register, which also updates the channel counters, is combinational
// reset: asynchronous, clears the pipeline, loads register defaults and counter
// reset values (send and trip counters 1, channel not synchronized)
module freshness_value_manager_core #(
	parameter int unsigned REPLAY_WIN = fvm_pkg::REPLAY_WIN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    mode,
	input  logic [63:0]                   rx_value,
	input  logic [31:0]                   sync_trip,
	input  logic [7:0]                    sync_reset,
	input  logic [63:0]                   sync_mac,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [63:0]                   tx_value,
	output logic [3:0]                    tx_length,
	output logic [31:0]                   out_trip,
	output logic [7:0]                    out_reset,
	output logic [2:0]                    fv_state,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fvm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	fvm_pkg::cfg_t    cfg;
	fvm_pkg::req_t    req_s1;
	fvm_pkg::result_t res;
	fvm_pkg::result_t res_s2;
	logic valid_s1, valid_s2;
	logic s2_free, advance, accept;

	assign cfg_ready = 1'b1;

	fvm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)       valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance)      valid_s2 <= 1'b1;
			else if (s2_free) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.mode       <= fvm_pkg::mode_t'(mode);
			req_s1.rx_value   <= rx_value;
			req_s1.sync_trip  <= sync_trip;
			req_s1.sync_reset <= sync_reset;
			req_s1.sync_mac   <= sync_mac;
		end
		if (advance) res_s2 <= res;
	end

	// channel state commits only when the request moves into the result register
	fvm_engine #(
		.REPLAY_WIN (REPLAY_WIN)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid = valid_s2;
	assign status    = res_s2.status;
	assign tx_value  = res_s2.tx_value;
	assign tx_length = res_s2.tx_length;
	assign out_trip  = res_s2.out_trip;
	assign out_reset = res_s2.out_reset;
	assign fv_state  = res_s2.fv_state;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty request stage");

	a_len_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tx_length != 4'd0) |-> (status == fvm_pkg::ST_OK))
		else $error("length code on a failed request");

	a_replay_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == fvm_pkg::ST_REPLAY) |-> (fv_state == fvm_pkg::CS_REPLAY))
		else $error("replay status without replay channel state");

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == fvm_pkg::ST_INVALID) |->
		(tx_value == 64'd0 && out_trip == 32'd0 && out_reset == 8'd0))
		else $error("invalid request produced payload");

endmodule

/* tb/sv/freshness_value_manager_core_tb.sv */
module freshness_value_manager_core_tb;
	import fvm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASES = 12;
	localparam int unsigned PHASE_ITEMS = 108;
	localparam logic [63:0] WIN = 64'(REPLAY_WIN_DEF);
	localparam logic [63:0] HALF = 64'(REPLAY_WIN_DEF / 2);
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0]          data;
		req_t                 req;
		bit                   pinned;
		result_t              want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] mode = '0;
	logic [63:0] rx_value = '0;
	logic [31:0] sync_trip = '0;
	logic [7:0] sync_reset = '0;
	logic [63:0] sync_mac = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [63:0] tx_value;
	logic [3:0] tx_length;
	logic [31:0] out_trip;
	logic [7:0] out_reset;
	logic [2:0] fv_state;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// expectation pinned by a directed row, travels with the request
	bit row_pinned = 1'b0;
	result_t row_want = '0;

	bit quiet = 1'b0;
	int err_count = 0;
	int unsigned cycle_count = 0;
	result_t fv_expected[$];
	dir_row_t dir_rows[$];

	// predictor copy of the registers
	logic        fvk = 1'b0;
	logic [1:0]  role = '0;
	logic [63:0] max_cnt = MAX_COUNT_RST;
	logic [31:0] gap_lim = '0;
	logic [31:0] reorder = '0;
	logic [31:0] trip_lim = TRIP_LIM_RST;
	logic [7:0]  rst_lim = RESET_LIM_RST;

	// predictor copy of the channel state
	logic [63:0] send_cnt = 64'd1;
	logic [63:0] recv_cnt = '0;
	logic [63:0] last_ok = '0;
	logic [63:0] win_base = '0;
	logic [31:0] trip_cnt = 32'd1;
	logic [7:0]  rst_cnt = '0;
	logic        synced = 1'b0;
	chan_state_t chan = CS_NOT_SYNC;

	freshness_value_manager_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.rx_value  (rx_value),
		.sync_trip (sync_trip),
		.sync_reset(sync_reset),
		.sync_mac  (sync_mac),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.tx_value  (tx_value),
		.tx_length (tx_length),
		.out_trip  (out_trip),
		.out_reset (out_reset),
		.fv_state  (fv_state),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 14);

	function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
		case (idx)
			CFG_FV_KIND:   fvk = d[0];
			CFG_SYNC_ROLE: role = d[1:0];
			CFG_MAX_COUNT: max_cnt = d;
			CFG_GAP_LIMIT: gap_lim = d[31:0];
			CFG_REORDER:   reorder = d[31:0];
			CFG_TRIP_LIM:  trip_lim = d[31:0];
			CFG_RESET_LIM: rst_lim = d[7:0];
			default: ;
		endcase
	endfunction

	function automatic void step_trip();
		if (trip_cnt < trip_lim) begin
			trip_cnt++;
			send_cnt = 64'd1;
		end
	endfunction

	function automatic result_t fv_predict(req_t r);
		result_t o;
		logic [63:0] v;
		logic [63:0] gap;
		logic in_win;
		o = '0;
		v = r.rx_value;
		case (r.mode)
			MODE_GET_TX: begin
				if (!fvk) begin
					if (role == ROLE_SLAVE && !synced) begin
						chan = CS_NOT_SYNC;
						o.status = ST_SYNC_FAIL;
					end else if (send_cnt >= max_cnt) begin
						chan = CS_OVERFLOW;
						o.status = ST_OVERFLOW;
					end else begin
						o.tx_value = send_cnt;
						o.tx_length = (max_cnt > LEN4_THR) ? LEN_4B :
							(max_cnt > LEN3_THR) ? LEN_3B :
							(max_cnt > LEN2_THR) ? LEN_2B : LEN_1B;
					end
				end else begin
					o.tx_value = {trip_cnt, rst_cnt, send_cnt[23:0]};
					o.tx_length = LEN_8B;
				end
			end
			MODE_VERIFY: begin
				if (!fvk) begin
					in_win = (v >= win_base) && ((v - win_base) < WIN);
					gap = (v > recv_cnt) ? v - recv_cnt : '0;
					if ((in_win && v <= last_ok) ||
						(v <= last_ok && (last_ok - v) > {32'd0, reorder})) begin
						chan = CS_REPLAY;
						o.status = ST_REPLAY;
					end else if (role == ROLE_SLAVE && gap > {32'd0, gap_lim}) begin
						chan = CS_SYNC_BUSY;
						o.status = ST_SYNC_FAIL;
					end else begin
						recv_cnt = v;
						last_ok = v;
						chan = CS_OK;
						win_base = (v > HALF) ? v - HALF : '0;
					end
				end else begin
					// trip, then reset, then counter
					if (v[63:32] < trip_cnt || (v[63:32] == trip_cnt && (v[31:24] < rst_cnt ||
						(v[31:24] == rst_cnt && {40'd0, v[23:0]} <= last_ok)))) begin
						chan = CS_REPLAY;
						o.status = ST_REPLAY;
					end else begin
						last_ok = {40'd0, v[23:0]};
						chan = CS_OK;
					end
				end
			end
			MODE_INC_COUNT: if (send_cnt < max_cnt) send_cnt++;
			MODE_INC_TRIP: step_trip();
			MODE_INC_RESET: begin
				if (rst_cnt < rst_lim) begin
					rst_cnt++;
					send_cnt = 64'd1;
				end else begin
					step_trip();
					rst_cnt = '0;
				end
			end
			MODE_SYNC_APPLY: begin
				if (role != ROLE_SLAVE) begin
					o.status = ST_INVALID;
				end else if (r.sync_mac != v) begin
					chan = CS_SYNC_FAILED;
					o.status = ST_SYNC_FAIL;
				end else begin
					recv_cnt = v;
					trip_cnt = r.sync_trip;
					rst_cnt = r.sync_reset;
					last_ok = v;
					synced = 1'b1;
					chan = CS_OK;
				end
			end
			MODE_FORCE_RESYNC: begin
				if (role != ROLE_SLAVE) begin
					o.status = ST_INVALID;
				end else begin
					chan = CS_SYNC_BUSY;
					synced = 1'b0;
					o.tx_value = {32'd0, recv_cnt[31:0]};
				end
			end
			default: begin
				if (role != ROLE_MASTER) begin
					o.status = ST_INVALID;
				end else begin
					o.tx_value = send_cnt;
					o.out_trip = trip_cnt;
					o.out_reset = rst_cnt;
				end
			end
		endcase
		o.fv_state = chan;
		return o;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : monitor
		result_t want;
		req_t cur;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (fv_expected.size() == 0) begin
					$error("result with no request pending");
					err_count++;
				end else begin
					want = fv_expected.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("tx_value", want.tx_value, tx_value);
					check_field("tx_length", 64'(want.tx_length), 64'(tx_length));
					check_field("out_trip", 64'(want.out_trip), 64'(out_trip));
					check_field("out_reset", 64'(want.out_reset), 64'(out_reset));
					check_field("fv_state", 64'(want.fv_state), 64'(fv_state));
				end
			end
			if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				cur.mode = mode_t'(mode);
				cur.rx_value = rx_value;
				cur.sync_trip = sync_trip;
				cur.sync_reset = sync_reset;
				cur.sync_mac = sync_mac;
				want = fv_predict(cur);
				if (row_pinned) want = row_want;
				fv_expected.push_back(want);
			end
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (fv_expected.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_req(req_t r, bit pin, result_t w);
		while (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		rx_value <= r.rx_value;
		sync_trip <= r.sync_trip;
		sync_reset <= r.sync_reset;
		sync_mac <= r.sync_mac;
		row_pinned <= pin;
		row_want <= w;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic dir_row_t op_row(mode_t m, logic [63:0] rx, logic [31:0] tr,
		logic [7:0] rs, logic [63:0] mac);
		dir_row_t d;
		d.is_cfg = 1'b0;
		d.idx = '0;
		d.data = '0;
		d.req.mode = m;
		d.req.rx_value = rx;
		d.req.sync_trip = tr;
		d.req.sync_reset = rs;
		d.req.sync_mac = mac;
		d.pinned = 1'b0;
		d.want = '0;
		return d;
	endfunction

	function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		dir_row_t d;
		d = op_row(MODE_GET_TX, '0, '0, '0, '0);
		d.is_cfg = 1'b1;
		d.idx = idx;
		d.data = data;
		return d;
	endfunction

	function automatic dir_row_t with_result(dir_row_t d, logic [2:0] st, logic [63:0] tx,
		logic [3:0] len, chan_state_t fs);
		d.pinned = 1'b1;
		d.want = '0;
		d.want.status = st;
		d.want.tx_value = tx;
		d.want.tx_length = len;
		d.want.fv_state = fs;
		return d;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(3))
			0: return '0;
			1: return $urandom_range(1, 40);
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_max_count();
		case ($urandom_range(8))
			0: return 64'($urandom_range(1, 20));
			1: return 64'hFF;
			2: return 64'h100;
			3: return 64'hFFFF;
			4: return 64'h1_0000;
			5: return 64'hFF_FFFF;
			6: return 64'h100_0000;
			7: return ALL_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mostly values near the live counters so the checks past the replay test are reached
	function automatic req_t random_req();
		req_t r;
		int unsigned pick;
		logic [31:0] t;
		logic [7:0] s;
		logic [23:0] c;
		pick = $urandom_range(99);
		r.rx_value = {$urandom, $urandom};
		r.sync_trip = $urandom;
		r.sync_reset = 8'($urandom);
		r.sync_mac = {$urandom, $urandom};
		if (pick < 15) r.mode = MODE_GET_TX;
		else if (pick < 45) r.mode = MODE_VERIFY;
		else if (pick < 60) r.mode = MODE_INC_COUNT;
		else if (pick < 65) r.mode = MODE_INC_TRIP;
		else if (pick < 72) r.mode = MODE_INC_RESET;
		else if (pick < 84) r.mode = MODE_SYNC_APPLY;
		else if (pick < 90) r.mode = MODE_FORCE_RESYNC;
		else r.mode = MODE_SYNC_RESPONSE;
		case (r.mode)
			MODE_VERIFY: begin
				if (fvk && $urandom_range(9) < 8) begin
					t = trip_cnt + $urandom_range(2) - 1;
					s = 8'(rst_cnt + $urandom_range(2) - 1);
					c = 24'(last_ok[23:0] + $urandom_range(6) - 3);
					r.rx_value = {t, s, c};
				end else begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4, 5: r.rx_value = last_ok + $urandom_range(40) - 20;
						6, 7: r.rx_value = last_ok + $urandom;
						8: r.rx_value = win_base + $urandom_range(70);
						default: ;
					endcase
				end
			end
			MODE_SYNC_APPLY: begin
				if ($urandom_range(1)) r.rx_value = last_ok + $urandom_range(100);
				if ($urandom_range(9) < 8) r.sync_trip = $urandom_range(12);
				if ($urandom_range(9) < 8) r.sync_mac = r.rx_value;
				else if ($urandom_range(1)) r.sync_mac = r.rx_value ^ (64'd1 << $urandom_range(63));
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		dir_rows.push_back(with_result(op_row(MODE_GET_TX, '0, '0, '0, '0),
			ST_OK, 64'd1, LEN_3B, CS_NOT_SYNC));
		dir_rows.push_back(with_result(op_row(MODE_SYNC_RESPONSE, '0, '0, '0, '0),
			ST_INVALID, '0, '0, CS_NOT_SYNC));
		dir_rows.push_back(with_result(op_row(MODE_SYNC_APPLY, 64'd5, '0, '0, 64'd5),
			ST_INVALID, '0, '0, CS_NOT_SYNC));
		dir_rows.push_back(with_result(op_row(MODE_FORCE_RESYNC, '0, '0, '0, '0),
			ST_INVALID, '0, '0, CS_NOT_SYNC));
		dir_rows.push_back(with_result(op_row(MODE_VERIFY, '0, '0, '0, '0),
			ST_REPLAY, '0, '0, CS_REPLAY));
		dir_rows.push_back(with_result(op_row(MODE_VERIFY, ALL_ONES, '0, '0, '0),
			ST_OK, '0, '0, CS_OK));
		dir_rows.push_back(with_result(op_row(MODE_VERIFY, ALL_ONES, '0, '0, '0),
			ST_REPLAY, '0, '0, CS_REPLAY));
		dir_rows.push_back(op_row(MODE_VERIFY, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_INC_COUNT, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_GET_TX, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_INC_TRIP, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_INC_RESET, '0, '0, '0, '0));
		// counter limit reached at once
		dir_rows.push_back(cfg_row(CFG_MAX_COUNT, '0));
		dir_rows.push_back(with_result(op_row(MODE_GET_TX, '0, '0, '0, '0),
			ST_OVERFLOW, '0, '0, CS_OVERFLOW));
		dir_rows.push_back(cfg_row(CFG_MAX_COUNT, ALL_ONES));
		dir_rows.push_back(op_row(MODE_GET_TX, '0, '0, '0, '0));
		dir_rows.push_back(cfg_row(CFG_SYNC_ROLE, 64'(ROLE_SLAVE)));
		dir_rows.push_back(with_result(op_row(MODE_GET_TX, '0, '0, '0, '0),
			ST_SYNC_FAIL, '0, '0, CS_NOT_SYNC));
		dir_rows.push_back(with_result(op_row(MODE_SYNC_APPLY, 64'd5, '0, '0, 64'd6),
			ST_SYNC_FAIL, '0, '0, CS_SYNC_FAILED));
		dir_rows.push_back(with_result(op_row(MODE_SYNC_APPLY, 64'd100, 32'd7, 8'd3, 64'd100),
			ST_OK, '0, '0, CS_OK));
		dir_rows.push_back(op_row(MODE_VERIFY, 64'd200, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_FORCE_RESYNC, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_GET_TX, '0, '0, '0, '0));
		dir_rows.push_back(cfg_row(CFG_SYNC_ROLE, 64'(ROLE_MASTER)));
		dir_rows.push_back(cfg_row(CFG_FV_KIND, 64'd1));
		dir_rows.push_back(op_row(MODE_SYNC_RESPONSE, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_GET_TX, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_VERIFY, ALL_ONES, '0, '0, '0));
		// saturated limits, role code 3 behaves as no role
		dir_rows.push_back(cfg_row(CFG_TRIP_LIM, '0));
		dir_rows.push_back(cfg_row(CFG_RESET_LIM, '0));
		dir_rows.push_back(cfg_row(CFG_GAP_LIMIT, 64'hFFFF_FFFF));
		dir_rows.push_back(cfg_row(CFG_REORDER, 64'hFFFF_FFFF));
		dir_rows.push_back(cfg_row(CFG_SYNC_ROLE, 64'd3));
		dir_rows.push_back(cfg_row(CFG_FV_KIND, '0));
		dir_rows.push_back(op_row(MODE_INC_RESET, '0, '0, '0, '0));
		dir_rows.push_back(with_result(op_row(MODE_SYNC_APPLY, 64'd9, '0, '0, 64'd9),
			ST_INVALID, '0, '0, CS_OK));
		dir_rows.push_back(op_row(MODE_VERIFY, '0, '0, '0, '0));
		dir_rows.push_back(op_row(MODE_INC_TRIP, '0, '0, '0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_drained();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_req(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			quiet = (ph == 5 || ph == 6);
			write_reg(CFG_FV_KIND, 64'((ph / 4) % 2));
			write_reg(CFG_SYNC_ROLE, 64'(ph % 4));
			if (ph == 0) begin
				write_reg(CFG_MAX_COUNT, '0);
				write_reg(CFG_GAP_LIMIT, '0);
				write_reg(CFG_REORDER, '0);
				write_reg(CFG_TRIP_LIM, '0);
				write_reg(CFG_RESET_LIM, '0);
			end else if (ph == 1) begin
				write_reg(CFG_MAX_COUNT, ALL_ONES);
				write_reg(CFG_GAP_LIMIT, 64'hFFFF_FFFF);
				write_reg(CFG_REORDER, 64'hFFFF_FFFF);
				write_reg(CFG_TRIP_LIM, 64'hFFFF_FFFF);
				write_reg(CFG_RESET_LIM, 64'hFF);
			end else begin
				write_reg(CFG_MAX_COUNT, pick_max_count());
				write_reg(CFG_GAP_LIMIT, 64'(pick_word()));
				write_reg(CFG_REORDER, 64'(pick_word()));
				write_reg(CFG_TRIP_LIM, 64'((pick_word() % 13 == 0) ? 32'd0 : pick_word()));
				write_reg(CFG_RESET_LIM,
					64'($urandom_range(1) ? $urandom_range(4) : $urandom));
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// halfway through the phase, hold the sender until the pipeline is empty
				if (k == PHASE_ITEMS / 2) wait_drained();
				send_req(random_req(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (err_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
hdl/fvm_pkg.sv
hdl/fvm_cfg.sv
hdl/fvm_engine.sv
hdl/freshness_value_manager_core.sv
tb/sv/freshness_value_manager_core_tb.sv
